FILE: rtl/run_segment_image_moments_defines.svh
// Assertion macros for the run segment image moments block.
// Used by the RTL files that carry concurrent checks; needs clk and arst_n in scope.
`ifndef RUN_SEGMENT_IMAGE_MOMENTS_DEFINES_SVH
`define RUN_SEGMENT_IMAGE_MOMENTS_DEFINES_SVH
`ifndef SYNTHESIS
// ante holds -> cons holds in the same cycle
`define RSIM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// ante holds -> cons holds in the next cycle
`define RSIM_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define RSIM_ASSERT_IMP(lbl, ante, cons, msg)
`define RSIM_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/rsim_pkg.sv
// Shared types and constants of the run segment image moments block.
// No dependencies; used by the interfaces, the sequencer and the top level.
package rsim_pkg;

	// default coordinate width in bits
	localparam int COORD_BITS_DEF = 10;

	// products issued to the shared multiplier, in sequence order
	typedef enum logic [3:0] {
		OP_NONE,
		OP_Q,      // n times reciprocal of three
		OP_SK,     // sum of k over the segment
		OP_T,      // first two factors of the sum of k squared
		OP_XN,     // column times length
		OP_SK2,    // sum of k squared
		OP_NY,     // length times first row
		OP_NDY,    // length times row offset
		OP_NDX,    // length times column offset
		OP_CROSS,  // column offset times row offset sum
		OP_RV,     // row offset times (row offset sum plus sum of k)
		OP_CV      // column offset times length times column offset
	} mul_op_t;

	// sequencer outputs to the datapath
	typedef struct packed {
		logic    take;  // segment transaction accepted this cycle
		mul_op_t op;    // product issued this cycle
		logic    fin;   // segment done; on a last segment, results/clear applied this cycle
	} ctrl_t;

endpackage

FILE: rtl/rsim_if.sv
// Segment and moment channel interfaces (valid/ready with payload).
// Depends on rsim_pkg for the default coordinate width.
interface rsim_seg_if import rsim_pkg::*; #(parameter int CB = COORD_BITS_DEF) ();
	logic          valid;
	logic          ready;
	logic [CB-1:0] seg_col;
	logic [CB-1:0] seg_row;
	logic [CB:0]   seg_len;
	logic [CB-1:0] centre_col;
	logic [CB-1:0] centre_row;
	logic          last_seg;

	modport source (output valid, seg_col, seg_row, seg_len, centre_col, centre_row,
		last_seg, input ready);
	modport sink (input valid, seg_col, seg_row, seg_len, centre_col, centre_row,
		last_seg, output ready);
endinterface

interface rsim_mom_if import rsim_pkg::*; #(parameter int CB = COORD_BITS_DEF) ();
	logic                 valid;
	logic                 ready;
	logic [2*CB:0]        m00;
	logic [3*CB-1:0]      m10;
	logic [3*CB-1:0]      m01;
	logic [4*CB-1:0]      cm20;
	logic signed [4*CB:0] cm11;
	logic [4*CB-1:0]      cm02;

	modport source (output valid, m00, m10, m01, cm20, cm11, cm02, input ready);
	modport sink (input valid, m00, m10, m01, cm20, cm11, cm02, output ready);
endinterface

FILE: rtl/rsim_mul.sv
// Shared signed multiplier with a registered product.
// No dependencies; instantiated by the top level.
module rsim_mul #(
	parameter int AW = 13,
	parameter int BW = 24
) (
	input  logic                    clk,
	input  logic signed [AW-1:0]    a,
	input  logic signed [BW-1:0]    b,
	output logic signed [AW+BW-1:0] p_q
);

	// one product per cycle, registered
	always_ff @(posedge clk) begin
		p_q <= (AW+BW)'(a) * (AW+BW)'(b);
	end

endmodule

FILE: rtl/rsim_ctrl.sv
// Sequencer: steps the shared multiplier through the products of one segment.
// Depends on rsim_pkg for ctrl_t and mul_op_t.
module rsim_ctrl import rsim_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  logic  last,
	input  logic  out_busy,
	output logic  ready,
	output ctrl_t ctrl
);

	typedef enum logic [13:0] {
		ST_IDLE = 14'b00000000000001,
		ST_S0   = 14'b00000000000010,
		ST_S1   = 14'b00000000000100,
		ST_S2   = 14'b00000000001000,
		ST_S3   = 14'b00000000010000,
		ST_S4   = 14'b00000000100000,
		ST_S5   = 14'b00000001000000,
		ST_S6   = 14'b00000010000000,
		ST_S7   = 14'b00000100000000,
		ST_S8   = 14'b00001000000000,
		ST_S9   = 14'b00010000000000,
		ST_S10  = 14'b00100000000000,
		ST_S11  = 14'b01000000000000,
		ST_DONE = 14'b10000000000000
	} state_t;

	state_t state_q;
	state_t state_nx;
	logic   can_fin;

	// a last segment waits until the result register is free
	assign can_fin = !last || !out_busy;
	assign ready   = (state_q == ST_IDLE);

	// next state and issued product
	always_comb begin
		state_nx  = state_q;
		ctrl.take = 1'b0;
		ctrl.op   = OP_NONE;
		ctrl.fin  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					ctrl.take = 1'b1;
					state_nx  = ST_S0;
				end
			end
			ST_S0: begin
				ctrl.op  = OP_Q;
				state_nx = ST_S1;
			end
			ST_S1: begin
				ctrl.op  = OP_SK;
				state_nx = ST_S2;
			end
			ST_S2: begin
				ctrl.op  = OP_T;
				state_nx = ST_S3;
			end
			ST_S3: begin
				ctrl.op  = OP_XN;
				state_nx = ST_S4;
			end
			ST_S4: begin
				ctrl.op  = OP_SK2;
				state_nx = ST_S5;
			end
			ST_S5: begin
				ctrl.op  = OP_NY;
				state_nx = ST_S6;
			end
			ST_S6: begin
				ctrl.op  = OP_NDY;
				state_nx = ST_S7;
			end
			ST_S7: begin
				ctrl.op  = OP_NDX;
				state_nx = ST_S8;
			end
			ST_S8: begin
				ctrl.op  = OP_CROSS;
				state_nx = ST_S9;
			end
			ST_S9: begin
				ctrl.op  = OP_RV;
				state_nx = ST_S10;
			end
			ST_S10: begin
				ctrl.op  = OP_CV;
				state_nx = ST_S11;
			end
			ST_S11: begin
				state_nx = ST_DONE;
			end
			ST_DONE: begin
				if (can_fin) begin
					ctrl.fin = 1'b1;
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

endmodule

FILE: rtl/run_segment_image_moments.sv
// Image moments from vertical run segments. One segment transaction is accepted, then
// the block is busy: a sequencer feeds one shared multiplier eleven products per
// segment (sum-of-k and sum-of-k-squared factors, then the raw and central moment
// terms), and the next segment can be taken only after the sequencer returns to idle.
// On a segment flagged last, the six totals land in the output register at the end of
// the sequence and the accumulators clear; if an earlier result is still waiting, that
// last segment holds until it is taken. The next region can stream in while a result
// waits. Accumulators wrap at their widths, outputs are their low bits.
// Depends on rsim_pkg, rsim_if, rsim_mul, rsim_ctrl and the assertion macro header.
`include "run_segment_image_moments_defines.svh"
module run_segment_image_moments import rsim_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	rsim_seg_if.sink   seg,
	rsim_mom_if.source mom
);

	localparam int C  = COORD_BITS;
	localparam int AW = C + 3;          // multiplier A operand
	localparam int BW = 2*C + 4;        // multiplier B operand
	localparam int PW = AW + BW;        // product
	localparam int K  = 4*C + 2;        // widest accumulator
	localparam int QS = C + 3;          // reciprocal shift
	localparam logic [BW-1:0] RECIP = BW'(((64'd1 << QS) + 64'd2) / 64'd3);

	ctrl_t ctl;
	logic  out_busy;

	// segment registers
	logic [C-1:0]      x_q;
	logic [C-1:0]      y_q;
	logic [C:0]        n_q;
	logic signed [C:0] dx_q;
	logic signed [C:0] dy_q;
	logic              last_q;

	// intermediates
	logic [C:0]           q_q;
	logic [1:0]           r_q;
	logic [BW-1:0]        sk_q;
	logic signed [BW-1:0] t_q;
	logic signed [BW-1:0] ro_q;
	logic signed [BW-1:0] rs_q;
	logic signed [BW-1:0] ndx_q;
	mul_op_t              op_s1;

	// accumulators
	logic [2*C:0]   acc_area;
	logic [3*C:0]   acc_col_sum;
	logic [3*C:0]   acc_row_sum;
	logic [4*C:0]   acc_col_var;
	logic [K-1:0]   acc_cross;
	logic [4*C:0]   acc_row_var;

	// result register
	logic                out_valid_q;
	logic [2*C:0]        m00_q;
	logic [3*C-1:0]      m10_q;
	logic [3*C-1:0]      m01_q;
	logic [4*C-1:0]      cm20_q;
	logic signed [4*C:0] cm11_q;
	logic [4*C-1:0]      cm02_q;

	// multiplier operands and factors
	logic signed [AW-1:0] a_op;
	logic signed [BW-1:0] b_op;
	logic signed [PW-1:0] p_q;
	logic [K-1:0]         p_ext;
	logic [C:0]           q_new;
	logic [C:0]           n_m1;
	logic [C:0]           su;
	logic [C:0]           sv;
	logic [C:0]           uu;
	logic [C:0]           vv;
	logic [C+1:0]         ww;

	assign out_busy = out_valid_q && !mom.ready;

	rsim_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (seg.valid),
		.last     (last_q),
		.out_busy (out_busy),
		.ready    (seg.ready),
		.ctrl     (ctl)
	);

	rsim_mul #(.AW(AW), .BW(BW)) u_mul (
		.clk (clk),
		.a   (a_op),
		.b   (b_op),
		.p_q (p_q)
	);

	// factors of sum(k) and sum(k^2): divide out 2 and 3 before multiplying
	always_comb begin
		n_m1 = n_q - 1'b1;
		if (n_q[0]) begin
			su = n_m1 >> 1;
			sv = n_q;
		end else begin
			su = n_m1;
			sv = n_q >> 1;
		end
		uu = (r_q == 2'd1) ? q_q : n_m1;
		vv = (r_q == 2'd0) ? q_q : n_q;
		if (n_q[0]) begin
			uu = uu >> 1;
		end else begin
			vv = vv >> 1;
		end
		ww = (r_q == 2'd2) ? {q_q, 1'b1} : ({n_q, 1'b0} - 1'b1);
	end

	// operand select for the shared multiplier
	always_comb begin
		a_op = '0;
		b_op = '0;
		case (ctl.op)
			OP_Q: begin
				a_op = AW'(n_q);
				b_op = RECIP;
			end
			OP_SK: begin
				a_op = AW'(su);
				b_op = BW'(sv);
			end
			OP_T: begin
				a_op = AW'(uu);
				b_op = BW'(vv);
			end
			OP_XN: begin
				a_op = AW'(x_q);
				b_op = BW'(n_q);
			end
			OP_SK2: begin
				a_op = AW'(ww);
				b_op = t_q;
			end
			OP_NY: begin
				a_op = AW'(y_q);
				b_op = BW'(n_q);
			end
			OP_NDY: begin
				a_op = AW'(dy_q);
				b_op = BW'(n_q);
			end
			OP_NDX: begin
				a_op = AW'(dx_q);
				b_op = BW'(n_q);
			end
			OP_CROSS: begin
				a_op = AW'(dx_q);
				b_op = ro_q;
			end
			OP_RV: begin
				a_op = AW'(dy_q);
				b_op = rs_q;
			end
			OP_CV: begin
				a_op = AW'(dx_q);
				b_op = ndx_q;
			end
			default: begin
				a_op = '0;
				b_op = '0;
			end
		endcase
	end

	assign p_ext = K'(p_q);
	assign q_new = p_q[QS +: C+1];

	// segment capture and intermediate products
	always_ff @(posedge clk) begin
		if (ctl.take) begin
			x_q  <= seg.seg_col;
			y_q  <= seg.seg_row;
			n_q  <= seg.seg_len;
			dx_q <= signed'({1'b0, seg.seg_col}) - signed'({1'b0, seg.centre_col});
			dy_q <= signed'({1'b0, seg.seg_row}) - signed'({1'b0, seg.centre_row});
		end
		case (op_s1)
			OP_Q: begin
				q_q <= q_new;
				r_q <= 2'(n_q - (q_new + (q_new << 1)));
			end
			OP_SK: begin
				sk_q <= p_q[BW-1:0];
			end
			OP_T: begin
				t_q <= p_q[BW-1:0];
			end
			OP_NDY: begin
				ro_q <= p_q[BW-1:0] + sk_q;
			end
			OP_NDX: begin
				ndx_q <= p_q[BW-1:0];
				rs_q  <= ro_q + sk_q;
			end
			default: begin
			end
		endcase
		if (ctl.fin && last_q) begin
			m00_q  <= acc_area;
			m10_q  <= acc_col_sum[3*C-1:0];
			m01_q  <= acc_row_sum[3*C-1:0];
			cm20_q <= acc_col_var[4*C-1:0];
			cm11_q <= acc_cross[4*C:0];
			cm02_q <= acc_row_var[4*C-1:0];
		end
	end

	// accumulators, last flag, issued-op pipe and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1       <= OP_NONE;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
			acc_area    <= '0;
			acc_col_sum <= '0;
			acc_row_sum <= '0;
			acc_col_var <= '0;
			acc_cross   <= '0;
			acc_row_var <= '0;
		end else begin
			op_s1 <= ctl.op;
			if (ctl.take) begin
				last_q   <= seg.last_seg;
				acc_area <= acc_area + (2*C+1)'(seg.seg_len);
			end
			case (op_s1)
				OP_SK:    acc_row_sum <= acc_row_sum + (3*C+1)'(p_q[BW-1:0]);
				OP_XN:    acc_col_sum <= acc_col_sum + p_ext[3*C:0];
				OP_NY:    acc_row_sum <= acc_row_sum + p_ext[3*C:0];
				OP_SK2:   acc_row_var <= acc_row_var + p_ext[4*C:0];
				OP_RV:    acc_row_var <= acc_row_var + p_ext[4*C:0];
				OP_CROSS: acc_cross   <= acc_cross + p_ext;
				OP_CV:    acc_col_var <= acc_col_var + p_ext[4*C:0];
				default: begin
				end
			endcase
			if (ctl.fin && last_q) begin
				out_valid_q <= 1'b1;
				acc_area    <= '0;
				acc_col_sum <= '0;
				acc_row_sum <= '0;
				acc_col_var <= '0;
				acc_cross   <= '0;
				acc_row_var <= '0;
			end else if (mom.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign mom.valid = out_valid_q;
	assign mom.m00   = m00_q;
	assign mom.m10   = m10_q;
	assign mom.m01   = m01_q;
	assign mom.cm20  = cm20_q;
	assign mom.cm11  = cm11_q;
	assign mom.cm02  = cm02_q;

	// checks
	`RSIM_ASSERT_NXT(a_busy_after_take, seg.valid && seg.ready, !seg.ready, "segment taken while busy")
	`RSIM_ASSERT_IMP(a_no_overrun, ctl.fin && last_q, !out_busy, "pending result overwritten")
	`RSIM_ASSERT_NXT(a_clear_after_last, ctl.fin && last_q, acc_area == '0 && acc_cross == '0, "accumulators not cleared")
	`RSIM_ASSERT_IMP(a_div3, op_s1 == OP_T, n_q == q_q + (q_q << 1) + (C+1)'(r_q) && r_q != 2'd3, "length split by three is wrong")

endmodule

FILE: tb/run_segment_image_moments_test.sv
// Self-checking test of run_segment_image_moments: directed and random run segment regions,
// with predicted moment totals checked at the output channel.
// Depends on rsim_pkg, the rsim_seg_if / rsim_mom_if interfaces and the block's RTL.
module run_segment_image_moments_test;
	import rsim_pkg::*;

	localparam int CB = COORD_BITS_DEF;
	localparam int COORD_MAX = (1 << CB) - 1;
	localparam int LEN_MAX = 1 << CB;
	localparam int RANDOM_SEGS = 1000;
	localparam int LONG_REGION_SEGS = 200;
	localparam int DRAIN_CYCLES = 64;
	localparam int CYCLE_LIMIT = 1000000;

	// one segment transaction plus a flag that holds it back until all results are in
	typedef struct {
		logic [CB-1:0] col;
		logic [CB-1:0] row;
		logic [CB:0]   len;
		logic [CB-1:0] ccol;
		logic [CB-1:0] crow;
		logic          last;
		bit            drain_first;
	} seg_item_t;

	typedef struct {
		logic [2*CB:0]        m00;
		logic [3*CB-1:0]      m10;
		logic [3*CB-1:0]      m01;
		logic [4*CB-1:0]      cm20;
		logic signed [4*CB:0] cm11;
		logic [4*CB-1:0]      cm02;
	} moments_t;

	logic clk;
	logic arst_n;

	rsim_seg_if #(.CB(CB)) seg_bus ();
	rsim_mom_if #(.CB(CB)) mom_bus ();

	run_segment_image_moments #(.COORD_BITS(CB)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.seg    (seg_bus),
		.mom    (mom_bus)
	);

	seg_item_t segs_to_send[$];
	moments_t  moments_due[$];
	int        moment_errors;
	int        cycle_count;

	// running sums of the region in progress, at the block's accumulator widths
	logic [2*CB:0]   area_sum;
	logic [3*CB:0]   col_sum;
	logic [3*CB:0]   row_sum;
	logic [4*CB:0]   col_var_sum;
	logic [4*CB+1:0] cross_sum;
	logic [4*CB:0]   row_var_sum;

	// clock
	initial clk = 1'b0;
	always #2 clk = ~clk;

	// add one segment's share to the region sums; on the last one queue the totals
	task automatic add_segment_moments(input logic [CB-1:0] col, input logic [CB-1:0] row,
			input logic [CB:0] len, input logic [CB-1:0] ccol, input logic [CB-1:0] crow,
			input logic last);
		logic [63:0] x, y, n, dx, dy, sk, sk2, rows, rows_off, rows_off2;
		moments_t tot;
		x = 64'(col);
		y = 64'(row);
		n = 64'(len);
		dx = x - 64'(ccol);
		dy = y - 64'(crow);
		// closed forms of sum(k) and sum(k^2) for k = 0..n-1
		sk = (n * (n - 64'd1)) / 64'd2;
		sk2 = (n == 64'd0) ? 64'd0 : ((n - 64'd1) * n * (64'd2 * n - 64'd1)) / 64'd6;
		rows = n * y + sk;
		rows_off = n * dy + sk;
		rows_off2 = n * dy * dy + 64'd2 * dy * sk + sk2;
		area_sum = (2*CB+1)'(area_sum + n);
		col_sum = (3*CB+1)'(col_sum + x * n);
		row_sum = (3*CB+1)'(row_sum + rows);
		col_var_sum = (4*CB+1)'(col_var_sum + n * dx * dx);
		cross_sum = (4*CB+2)'(cross_sum + dx * rows_off);
		row_var_sum = (4*CB+1)'(row_var_sum + rows_off2);
		if (last) begin
			tot.m00 = area_sum;
			tot.m10 = col_sum[3*CB-1:0];
			tot.m01 = row_sum[3*CB-1:0];
			tot.cm20 = col_var_sum[4*CB-1:0];
			tot.cm11 = cross_sum[4*CB:0];
			tot.cm02 = row_var_sum[4*CB-1:0];
			moments_due = {moments_due, tot};
			area_sum = '0;
			col_sum = '0;
			row_sum = '0;
			col_var_sum = '0;
			cross_sum = '0;
			row_var_sum = '0;
		end
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			moment_errors++;
		end
	endtask

	task automatic queue_seg(input int col, input int row, input int len, input int ccol,
			input int crow, input bit last, input bit drain_first);
		seg_item_t s;
		s.col = col[CB-1:0];
		s.row = row[CB-1:0];
		s.len = len[CB:0];
		s.ccol = ccol[CB-1:0];
		s.crow = crow[CB-1:0];
		s.last = last;
		s.drain_first = drain_first;
		segs_to_send = {segs_to_send, s};
	endtask

	// coordinates lean toward the image edges now and then
	function automatic int pick_coord();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return COORD_MAX;
			default: return $urandom_range(0, COORD_MAX);
		endcase
	endfunction

	function automatic int pick_len();
		case ($urandom_range(0, 19))
			0: return 0;
			1: return LEN_MAX;
			2, 3: return $urandom_range(1, 8);
			default: return $urandom_range(0, LEN_MAX);
		endcase
	endfunction

	// segment sender: bursts of transactions separated by random gaps
	int        burst_left;
	int        gap_left;
	bit        present;
	seg_item_t head;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_bus.valid <= 1'b0;
			seg_bus.seg_col <= '0;
			seg_bus.seg_row <= '0;
			seg_bus.seg_len <= '0;
			seg_bus.centre_col <= '0;
			seg_bus.centre_row <= '0;
			seg_bus.last_seg <= 1'b0;
			burst_left = 1;
			gap_left = 0;
		end else begin
			if (seg_bus.valid && seg_bus.ready) begin
				add_segment_moments(seg_bus.seg_col, seg_bus.seg_row, seg_bus.seg_len,
					seg_bus.centre_col, seg_bus.centre_row, seg_bus.last_seg);
				void'(segs_to_send.pop_front());
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 300)
						: $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
				end
			end
			// a transaction on offer stays until taken
			if (!(seg_bus.valid && !seg_bus.ready)) begin
				present = 1'b0;
				if (gap_left > 0)
					gap_left--;
				else if (segs_to_send.size() > 0)
					present = !(segs_to_send[0].drain_first && moments_due.size() != 0);
				seg_bus.valid <= present;
				if (present) begin
					head = segs_to_send[0];
					seg_bus.seg_col <= head.col;
					seg_bus.seg_row <= head.row;
					seg_bus.seg_len <= head.len;
					seg_bus.centre_col <= head.ccol;
					seg_bus.centre_row <= head.crow;
					seg_bus.last_seg <= head.last;
				end
			end
		end
	end

	// result receiver: checks each transaction and stalls in changing modes
	int       ready_mode;
	moments_t want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mom_bus.ready <= 1'b0;
			ready_mode = 0;
		end else begin
			if (mom_bus.valid && mom_bus.ready) begin
				if (moments_due.size() == 0) begin
					$display("%0t: unexpected moments transaction, expected none, actual m00 %0h",
						$time, mom_bus.m00);
					moment_errors++;
				end else begin
					want = moments_due.pop_front();
					check_field("m00", 64'(want.m00), 64'(mom_bus.m00));
					check_field("m10", 64'(want.m10), 64'(mom_bus.m10));
					check_field("m01", 64'(want.m01), 64'(mom_bus.m01));
					check_field("cm20", 64'(want.cm20), 64'(mom_bus.cm20));
					check_field("cm11", 64'(want.cm11), 64'(mom_bus.cm11));
					check_field("cm02", 64'(want.cm02), 64'(mom_bus.cm02));
				end
			end
			if (cycle_count % 128 == 0)
				ready_mode = $urandom_range(0, 3);
			case (ready_mode)
				0: mom_bus.ready <= 1'b1;
				1: mom_bus.ready <= 1'($urandom_range(0, 1));
				2: mom_bus.ready <= ($urandom_range(0, 3) == 0);
				default: mom_bus.ready <= ($urandom_range(0, 15) != 0);
			endcase
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// stimulus, reset and end of run
	initial begin
		int random_segs;
		int nseg;
		int ccol;
		int crow;
		moment_errors = 0;
		cycle_count = 0;
		area_sum = '0;
		col_sum = '0;
		row_sum = '0;
		col_var_sum = '0;
		cross_sum = '0;
		row_var_sum = '0;
		arst_n = 1'b0;

		// directed: empty region, field extremes, rows past the image, negative offsets
		queue_seg(0, 0, 0, 0, 0, 1, 0);
		queue_seg(COORD_MAX, COORD_MAX, LEN_MAX, 0, 0, 1, 0);
		queue_seg(0, 0, LEN_MAX, COORD_MAX, COORD_MAX, 1, 0);
		queue_seg(COORD_MAX, 0, 1, 0, COORD_MAX, 0, 0);
		queue_seg(0, COORD_MAX, 0, 0, COORD_MAX, 1, 0);
		queue_seg('h2AA, 'h155, 'h2AA, 'h155, 'h2AA, 1, 0);
		queue_seg('h155, 'h2AA, 'h155, 'h2AA, 'h155, 1, 0);
		queue_seg(5, 7, 1, 5, 7, 0, 0);
		queue_seg(6, 7, 2, 5, 7, 0, 0);
		queue_seg(7, 6, 3, 5, 7, 1, 0);
		queue_seg(0, 0, 0, 3, 3, 0, 0);
		queue_seg(0, 0, 0, 3, 3, 0, 0);
		queue_seg(0, 0, 0, 3, 3, 1, 0);
		queue_seg(100, 900, 200, 600, 100, 0, 0);
		queue_seg(800, 1000, 1024, 20, 1000, 0, 0);
		queue_seg(512, 511, 513, 512, 512, 1, 0);
		queue_seg(COORD_MAX, COORD_MAX, LEN_MAX - 1, COORD_MAX, COORD_MAX, 1, 1);

		// random regions: mostly one centre per region, some noise segments
		random_segs = 0;
		while (random_segs < RANDOM_SEGS) begin
			if ($urandom_range(0, 6) != 0) begin
				nseg = $urandom_range(1, 8);
				ccol = pick_coord();
				crow = pick_coord();
				for (int i = 0; i < nseg; i++)
					queue_seg(pick_coord(), pick_coord(), pick_len(), ccol, crow, i == nseg - 1,
						i == 0 && $urandom_range(0, 30) == 0);
				random_segs += nseg;
			end else begin
				queue_seg(pick_coord(), pick_coord(), pick_len(), pick_coord(), pick_coord(),
					$urandom_range(0, 2) == 0, 0);
				random_segs++;
			end
			// one long full-size region builds large totals
			if (random_segs >= RANDOM_SEGS / 2 && random_segs < RANDOM_SEGS / 2 + 9
					&& segs_to_send[$].last) begin
				for (int i = 0; i < LONG_REGION_SEGS; i++)
					queue_seg(COORD_MAX, COORD_MAX, LEN_MAX, 0, 0, i == LONG_REGION_SEGS - 1,
						i == 0);
				random_segs += LONG_REGION_SEGS;
			end
		end
		// close any region left open by noise
		queue_seg(pick_coord(), pick_coord(), pick_len(), pick_coord(), pick_coord(), 1, 0);

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (segs_to_send.size() != 0)
			@(posedge clk);
		while (moments_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (moment_errors == 0 && moments_due.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
